// ===== design/schlick_reflectance_defines.svh =====
// assertion macros shared by the schlick reflectance rtl
// expects clk and arst_n in the scope of each use
`ifndef SCHLICK_REFLECTANCE_DEFINES_SVH
`define SCHLICK_REFLECTANCE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SREFL_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("schlick_reflectance: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define SREFL_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("schlick_reflectance: next-cycle check failed");

`endif

// ===== design/srefl_pkg.sv =====
// types and fixed-point constants of the schlick reflectance block
// no dependencies
package srefl_pkg;

	localparam int unsigned NumMedia = 6;

	typedef logic [2:0]  medium_t;
	typedef logic [2:0]  cfg_idx_t;
	typedef logic [13:0] angle_t;
	typedef logic [15:0] nidx_t;
	typedef logic [16:0] refl_t;
	typedef logic [31:0] word_t;
	typedef logic [30:0] q30_t;

	localparam medium_t  LAST_MEDIUM = 3'd5;
	localparam cfg_idx_t CFG_COUNT   = 3'd6;
	localparam angle_t   HALF_PI_Q13 = 14'd12868;
	localparam nidx_t    INDEX_RESET = 16'd4096;
	localparam q30_t     ONE_Q30     = 31'h4000_0000;
	localparam refl_t    ONE_Q16     = 17'h1_0000;

endpackage

// ===== design/srefl_ram.sv =====
// generic single-write, dual-read memory with registered read data
// no dependencies
module srefl_ram #(
	parameter int unsigned Width = 16,
	parameter int unsigned Depth = 6,
	localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr_a,
	input  logic [AddrW-1:0] raddr_b,
	output logic [Width-1:0] rdata_a,
	output logic [Width-1:0] rdata_b
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rd_a_q;
	logic [Width-1:0] rd_b_q;

	// write port and two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_a_q <= mem_q[raddr_a];
			rd_b_q <= mem_q[raddr_b];
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

// ===== design/srefl_cdiv.sv =====
// two-stage floor division of a 32-bit word by a constant
// depends on srefl_pkg; K must not be a power of two
module srefl_cdiv #(
	parameter int unsigned K = 90
) (
	input  logic            clk,
	input  logic            en,
	input  srefl_pkg::word_t num,
	output srefl_pkg::word_t quo
);
	import srefl_pkg::*;

	localparam int unsigned Shift     = 32 + $clog2(K + 1) - 1;
	localparam logic [63:0] RecipFull = (64'd1 << Shift) / 64'(K);
	localparam word_t       Recip     = RecipFull[31:0];
	localparam word_t       KW        = word_t'(K);

	logic [63:0] prod;
	word_t       est_s1;
	word_t       num_s1;
	word_t       rem;
	word_t       quo_s2;

	// reciprocal multiply gives the quotient or one below it
	assign prod = 64'(num) * 64'(Recip);

	always_ff @(posedge clk) begin
		if (en) begin
			est_s1 <= word_t'(prod >> Shift);
			num_s1 <= num;
		end
	end

	// one correction step
	assign rem = num_s1 - word_t'(est_s1 * KW);

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s2 <= (rem >= KW) ? est_s1 + 32'd1 : est_s1;
		end
	end

	assign quo = quo_s2;

endmodule

// ===== design/srefl_div.sv =====
// pipelined restoring divider, two quotient bits per stage, nine stages
// gives floor(num * 2^17 / den) for num <= den; no dependencies
module srefl_div (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] num,
	input  logic [33:0] den,
	output logic [17:0] quo
);

	localparam int unsigned StepsPerStage = 2;
	localparam int unsigned Stages        = 9;

	logic [34:0] rem_q [Stages-1];
	logic [33:0] den_q [Stages-1];
	logic [17:0] quo_q [Stages];

	for (genvar st = 0; st < Stages; st++) begin : g_stage
		logic [34:0] r_in;
		logic [34:0] r_n;
		logic [33:0] d_in;
		logic [17:0] q_in;
		logic [17:0] q_n;

		if (st == 0) begin : g_first
			assign r_in = {3'b000, num};
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_q[st-1];
			assign d_in = den_q[st-1];
			assign q_in = quo_q[st-1];
		end

		// compare, subtract, shift for each bit of this stage
		always_comb begin
			r_n = r_in;
			q_n = q_in;
			for (int k = 0; k < StepsPerStage; k++) begin
				q_n = {q_n[16:0], 1'b0};
				if (r_n >= {1'b0, d_in}) begin
					r_n  = r_n - {1'b0, d_in};
					q_n[0] = 1'b1;
				end
				r_n = {r_n[33:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[st] <= q_n;
			end
		end

		if (st < Stages - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[st] <= r_n;
					den_q[st] <= d_in;
				end
			end
		end
	end

	assign quo = quo_q[Stages-1];

endmodule

// ===== design/schlick_reflectance.sv =====
// Schlick reflectance: one request per cycle while the result output is not stalled.
// The cosine Horner chain (four multiply and constant-divide steps) sets the depth;
// f0 comes from a nine-stage divider running alongside it.
// Reset clears the valid bits and the written flags of the index table; an index
// never written reads as 1.0. Depends on srefl_pkg, srefl_ram, srefl_cdiv, srefl_div.
`include "schlick_reflectance_defines.svh"

module schlick_reflectance (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  srefl_pkg::medium_t  medium_in,
	input  srefl_pkg::medium_t  medium_out,
	input  srefl_pkg::angle_t   incidence_angle,
	output logic                result_valid,
	input  logic                result_stall,
	output srefl_pkg::refl_t    reflectance,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  srefl_pkg::cfg_idx_t cfg_index,
	input  srefl_pkg::nidx_t    cfg_data
);
	import srefl_pkg::*;

	localparam int unsigned Lat = 20;

	function automatic medium_t pick_medium(medium_t id);
		return (id > LAST_MEDIUM) ? LAST_MEDIUM : id;
	endfunction

	// (a * b) >> 30 for a Q30 step with a 32-bit operand
	function automatic word_t mul_x2(word_t a, q30_t b);
		logic [62:0] p;
		p = 63'(a) * 63'(b);
		return p[61:30];
	endfunction

	function automatic q30_t mul_q30(q30_t a, q30_t b);
		logic [61:0] p;
		p = 62'(a) * 62'(b);
		return p[60:30];
	endfunction

	function automatic q30_t one_minus(word_t q);
		return ONE_Q30 - q[30:0];
	endfunction

	logic            en;
	logic [Lat:1]    vld_q;
	logic            cfg_we;
	logic [NumMedia-1:0] ent_vld_q;
	medium_t         sel_in;
	medium_t         sel_out;
	nidx_t           rd_a;
	nidx_t           rd_b;

	angle_t          a_s1;
	logic            ev_a_s1;
	logic            ev_b_s1;
	nidx_t           n1;
	nidx_t           n2;
	logic [27:0]     asq;
	logic [15:0]     dn_s2;
	logic [16:0]     tn_s2;
	logic [31:0]     dn2_s3;
	logic [33:0]     tn2_s3;
	logic [17:0]     quo;
	logic            tz_q [2:12];
	refl_t           f0_q [13:19];
	word_t           x2_q [2:13];
	word_t           q90;
	word_t           q56;
	word_t           q30v;
	word_t           q12;
	word_t           p_s5;
	word_t           p_s8;
	word_t           p_s11;
	word_t           p_s14;
	q30_t            m_s15;
	q30_t            m_s16;
	q30_t            m_s17;
	q30_t            m2_s16;
	q30_t            m4_s17;
	q30_t            m5_s18;
	logic [47:0]     prp;
	logic [17:0]     pr_s19;
	logic [17:0]     sum;
	refl_t           refl_s20;

	// global advance: the whole pipe holds while the result waits
	assign en           = !(vld_q[Lat] && result_stall);
	assign item_stall   = !en;
	assign result_valid = vld_q[Lat];
	assign cfg_ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Lat-1:1], item_valid};
		end
	end

	// index table writes and written flags
	assign cfg_we = cfg_valid && (cfg_index < CFG_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (cfg_we) begin
			ent_vld_q[cfg_index] <= 1'b1;
		end
	end

	assign sel_in  = pick_medium(medium_in);
	assign sel_out = pick_medium(medium_out);

	srefl_ram #(
		.Width(16),
		.Depth(NumMedia)
	) u_table (
		.clk    (clk),
		.we     (cfg_we),
		.waddr  (cfg_index),
		.wdata  (cfg_data),
		.re     (en),
		.raddr_a(sel_in),
		.raddr_b(sel_out),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	// stage 1: angle clamp, table read
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= (incidence_angle > HALF_PI_Q13) ? HALF_PI_Q13 : incidence_angle;
			ev_a_s1 <= ent_vld_q[sel_in];
			ev_b_s1 <= ent_vld_q[sel_out];
		end
	end

	// stage 2: index difference and sum, angle squared
	assign n1  = ev_a_s1 ? rd_a : INDEX_RESET;
	assign n2  = ev_b_s1 ? rd_b : INDEX_RESET;
	assign asq = 28'(a_s1) * 28'(a_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			dn_s2    <= (n1 >= n2) ? n1 - n2 : n2 - n1;
			tn_s2    <= 17'(n1) + 17'(n2);
			tz_q[2]  <= (n1 == '0) && (n2 == '0);
			x2_q[2]  <= {asq, 4'b0000};
		end
	end

	// stage 3: squares for f0
	always_ff @(posedge clk) begin
		if (en) begin
			dn2_s3 <= 32'(dn_s2) * 32'(dn_s2);
			tn2_s3 <= 34'(tn_s2) * 34'(tn_s2);
		end
	end

	// f0 divider, stages 4 to 12
	srefl_div u_div (
		.clk(clk),
		.en (en),
		.num(dn2_s3),
		.den(tn2_s3),
		.quo(quo)
	);

	// delay lines for the zero-sum flag, f0 and x2
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 3; i <= 12; i++) begin
				tz_q[i] <= tz_q[i-1];
			end
			f0_q[13] <= tz_q[12] ? '0 : quo[17:1];
			for (int i = 14; i <= 19; i++) begin
				f0_q[i] <= f0_q[i-1];
			end
			for (int i = 3; i <= 13; i++) begin
				x2_q[i] <= x2_q[i-1];
			end
		end
	end

	// cosine horner chain
	srefl_cdiv #(.K(90)) u_c90 (.clk(clk), .en(en), .num(x2_q[2]), .quo(q90));

	always_ff @(posedge clk) begin
		if (en) begin
			p_s5 <= mul_x2(x2_q[4], one_minus(q90));
		end
	end

	srefl_cdiv #(.K(56)) u_c56 (.clk(clk), .en(en), .num(p_s5), .quo(q56));

	always_ff @(posedge clk) begin
		if (en) begin
			p_s8 <= mul_x2(x2_q[7], one_minus(q56));
		end
	end

	srefl_cdiv #(.K(30)) u_c30 (.clk(clk), .en(en), .num(p_s8), .quo(q30v));

	always_ff @(posedge clk) begin
		if (en) begin
			p_s11 <= mul_x2(x2_q[10], one_minus(q30v));
		end
	end

	srefl_cdiv #(.K(12)) u_c12 (.clk(clk), .en(en), .num(p_s11), .quo(q12));

	always_ff @(posedge clk) begin
		if (en) begin
			p_s14 <= mul_x2(x2_q[13], one_minus(q12));
		end
	end

	// one minus cosine, with cosine floored at zero
	always_ff @(posedge clk) begin
		if (en) begin
			m_s15 <= (p_s14[31:1] >= ONE_Q30) ? ONE_Q30 : p_s14[31:1];
		end
	end

	// fifth power in three multiplies
	always_ff @(posedge clk) begin
		if (en) begin
			m2_s16 <= mul_q30(m_s15, m_s15);
			m_s16  <= m_s15;
			m4_s17 <= mul_q30(m2_s16, m2_s16);
			m_s17  <= m_s16;
			m5_s18 <= mul_q30(m4_s17, m_s17);
		end
	end

	// blend and saturate
	assign prp = 48'(ONE_Q16 - f0_q[18]) * 48'(m5_s18);
	assign sum = 18'(f0_q[19]) + pr_s19;

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s19   <= prp[47:30];
			refl_s20 <= (sum > 18'(ONE_Q16)) ? ONE_Q16 : sum[16:0];
		end
	end

	assign reflectance = refl_s20;

	// checks
	`SREFL_ASSERT_IMPL(a_refl_le_one, result_valid, reflectance <= ONE_Q16)
	`SREFL_ASSERT_NEXT(a_no_loss, vld_q[Lat-1] && en, result_valid)
	`SREFL_ASSERT_IMPL(a_cos_term, vld_q[15], m_s15 <= ONE_Q30)
	`SREFL_ASSERT_IMPL(a_f0_le_one, vld_q[13], f0_q[13] <= ONE_Q16)

endmodule

// ===== verif/tb.sv =====
// testbench for schlick_reflectance: directed and random requests, checked against
// an in-bench fixed-point predictor of the fresnel approximation
// depends on srefl_pkg and the schlick_reflectance rtl
`timescale 1ns / 100ps

module tb;
	import srefl_pkg::*;

	logic     clk;
	logic     arst_n;
	logic     item_valid;
	logic     item_stall;
	medium_t  medium_in;
	medium_t  medium_out;
	angle_t   incidence_angle;
	logic     result_valid;
	logic     result_stall;
	refl_t    reflectance;
	logic     cfg_valid;
	logic     cfg_ready;
	cfg_idx_t cfg_index;
	nidx_t    cfg_data;

	schlick_reflectance DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.medium_in(medium_in), .medium_out(medium_out),
		.incidence_angle(incidence_angle),
		.result_valid(result_valid), .result_stall(result_stall),
		.reflectance(reflectance),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	localparam int LATENCY  = 20;
	localparam int HOLD_LEN = 60;

	// predictor copy of the index table
	nidx_t  index_table [NumMedia];
	refl_t  pending_refl [$];
	int     mismatches = 0;
	bit     rand_gaps;
	// receiver pacing: long hold-off requests and per-result waits
	int     hold_requests = 0;
	int     hold_seen = 0;
	int     hold_cycles = 0;
	int     wait_left = 0;
	int     results_taken = 0;
	int     results_seen = 0;

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	initial begin
		#200ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int unsigned medium_slot(medium_t id);
		return (id >= NumMedia) ? NumMedia - 1 : int'(id);
	endfunction

	// cosine of a clamped q1.13 angle via horner taylor series, q30
	function automatic longint unsigned cos_horner(longint unsigned a);
		longint unsigned one, x, x2, t, sub;
		one = 64'd1 << 30;
		x = a << 17;
		x2 = (x * x) >> 30;
		t = one - x2 / 90;
		t = one - ((x2 * t) >> 30) / 56;
		t = one - ((x2 * t) >> 30) / 30;
		t = one - ((x2 * t) >> 30) / 12;
		sub = ((x2 * t) >> 30) / 2;
		return (sub >= one) ? 64'd0 : one - sub;
	endfunction

	function automatic refl_t predict_reflectance(medium_t mi, medium_t mo, angle_t ang);
		longint unsigned n1, n2, dn, tn, f0, a, m, m2, m4, m5, r;
		n1 = index_table[medium_slot(mi)];
		n2 = index_table[medium_slot(mo)];
		a = (ang > HALF_PI_Q13) ? HALF_PI_Q13 : ang;
		dn = (n1 >= n2) ? n1 - n2 : n2 - n1;
		tn = n1 + n2;
		f0 = (tn == 0) ? 0 : ((dn * dn) << 16) / (tn * tn);
		if (f0 > 65536) f0 = 65536;
		m = (64'd1 << 30) - cos_horner(a);
		m2 = (m * m) >> 30;
		m4 = (m2 * m2) >> 30;
		m5 = (m4 * m) >> 30;
		r = f0 + (((65536 - f0) * m5) >> 30);
		if (r > 65536) r = 65536;
		return refl_t'(r);
	endfunction

	// send one request, with an optional random gap first; valid stays high
	// after acceptance until the next gap or the drain
	task automatic send_request(medium_t mi, medium_t mo, angle_t ang);
		int gap;
		gap = rand_gaps ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		medium_in <= mi;
		medium_out <= mo;
		incidence_angle <= ang;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		pending_refl.push_back(predict_reflectance(mi, mo, ang));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (pending_refl.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// register write while idle
	task automatic write_index(cfg_idx_t idx, nidx_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx < CFG_COUNT) index_table[idx] = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// receiver stall: a random wait before each result, or a long hold-off when asked
	always @(negedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_cycles = HOLD_LEN;
		end
		if (results_seen != results_taken) begin
			results_seen = results_taken;
			wait_left = rand_gaps ? $urandom_range(0, 7) : 0;
		end
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_cycles > 0) begin
			result_stall <= 1'b1;
			hold_cycles--;
		end else if (wait_left > 0) begin
			result_stall <= 1'b1;
			wait_left--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		refl_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			results_taken++;
			if (pending_refl.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result reflectance=%0d", reflectance);
			end else begin
				exp_r = pending_refl.pop_front();
				if (reflectance !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("reflectance mismatch: expected %0d actual %0d",
							exp_r, reflectance);
				end
			end
		end
	end

	task automatic test_directed_extremes();
		write_index(3'd0, 16'd4096);
		write_index(3'd1, 16'd6144);
		write_index(3'd2, 16'hFFFF);
		write_index(3'd3, 16'd0);
		write_index(3'd4, 16'd0);
		write_index(3'd5, 16'd100);
		write_index(3'd6, 16'd1234);
		write_index(3'd7, 16'd4321);
		send_request(3'd0, 3'd1, 14'd0);
		send_request(3'd0, 3'd1, HALF_PI_Q13);
		send_request(3'd0, 3'd1, 14'h3FFF);
		send_request(3'd1, 3'd0, 14'd12869);
		send_request(3'd0, 3'd2, 14'd6000);
		send_request(3'd2, 3'd5, 14'd12000);
		send_request(3'd3, 3'd4, 14'd8000);
		send_request(3'd3, 3'd2, 14'd0);
		send_request(3'd6, 3'd7, 14'd5000);
		send_request(3'd7, 3'd0, 14'd2000);
		send_request(3'd5, 3'd6, 14'd12860);
		send_request(3'd2, 3'd2, 14'h2AAA);
		send_request(3'd1, 3'd3, 14'h1555);
		wait_drained();
	endtask

	task automatic test_random_stream(int count);
		for (int i = 0; i < count; i++)
			send_request(medium_t'($urandom_range(0, 7)), medium_t'($urandom_range(0, 7)),
				($urandom_range(0, 3) == 0) ? angle_t'($urandom_range(12800, 16383))
				: angle_t'($urandom));
	endtask

	task automatic test_reconfigure();
		for (int i = 0; i < 8; i++)
			write_index(cfg_idx_t'(i), ($urandom_range(0, 3) == 0) ? nidx_t'($urandom)
				: nidx_t'($urandom_range(4096, 12288)));
	endtask

	task automatic test_backpressure();
		rand_gaps = 0;
		hold_requests++;
		test_random_stream(50);
		rand_gaps = 1;
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		medium_in = '0;
		medium_out = '0;
		incidence_angle = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		rand_gaps = 0;
		for (int i = 0; i < NumMedia; i++) index_table[i] = INDEX_RESET;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_extremes();
		rand_gaps = 1;
		for (int p = 0; p < 4; p++) begin
			test_reconfigure();
			test_random_stream(200);
			wait_drained();
		end
		rand_gaps = 0;
		test_random_stream(50);
		wait_drained();
		test_backpressure();

		if (mismatches == 0 && pending_refl.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
